/* sv/llf_pkg.sv */
// Package for the lead-lag filter: data widths, fixed-point helpers, the
// microcode word layout and the control program held in a read-only table.
// No dependencies; every other file of the block refers to it by scoped names.
package llf_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 16;
    localparam int DT_FRAC   = 16;
    localparam int OPND_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int MAG_W     = ACC_W - 1;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 5;
    localparam int CNT_W     = 5;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [DT_W-1:0]          dt_t;
    typedef logic [STEP_W-1:0]        step_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    localparam data_t DATA_MAX = data_t'({1'b0, {(DATA_W-1){1'b1}}});
    localparam data_t DATA_MIN = data_t'({1'b1, {(DATA_W-1){1'b0}}});
    localparam opnd_t FIX_TWO  = opnd_t'(2 * (1 << FRAC_BITS));
    localparam cnt_t  DIV_LAST = cnt_t'(DATA_W - 1);
    localparam data_t GAIN_ONE = data_t'(1 << FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_COEF,
        REG_POLE_COEF,
        REG_DC_GAIN,
        REG_INPUT_GAIN,
        REG_INPUT_OFFSET
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MA_SAMPLE,
        MA_TEMP,
        MA_ZERO,
        MA_POLE,
        MA_COEF
    } mula_t;

    typedef enum logic [2:0] {
        MB_GAIN,
        MB_DC,
        MB_DT,
        MB_YPREV,
        MB_X,
        MB_XPREV
    } mulb_t;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_TWO_MINUS_B,
        CO_A_PLUS_TWO,
        CO_A_MINUS_TWO,
        CO_TWO_PLUS_B
    } coef_op_t;

    typedef enum logic [1:0] {
        AO_HOLD,
        AO_SET,
        AO_ADD
    } acc_op_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_SAT_T,
        ACT_ADD_OFS,
        ACT_SAT_X,
        ACT_LD_ADT,
        ACT_LD_BDT,
        ACT_PREP,
        ACT_DIV_INIT,
        ACT_DIV,
        ACT_FIN,
        ACT_SAT_OVF,
        ACT_ZDIV,
        ACT_OUT
    } act_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_WAIT_IN,
        J_WAIT_OUT,
        J_DEN_ZERO,
        J_QUO_OVF,
        J_LOOP
    } jmp_t;

    typedef struct packed {
        mula_t    mula;
        mulb_t    mulb;
        logic     mul_en;
        coef_op_t coef_op;
        acc_op_t  acc_op;
        act_t     act;
        jmp_t     jmp;
        step_t    target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic den_zero;
        logic quo_ovf;
        logic cnt_zero;
    } cond_t;

    typedef struct packed {
        uword_t uw;
        logic   go;
    } ctrl_t;

    typedef struct packed {
        logic  ovf;
        data_t val;
    } sat_res_t;

    localparam step_t S_IDLE     = step_t'(0);
    localparam step_t S_MUL_SG   = step_t'(1);
    localparam step_t S_SAT_T    = step_t'(2);
    localparam step_t S_ADD_OFS  = step_t'(3);
    localparam step_t S_MUL_DC   = step_t'(4);
    localparam step_t S_SAT_X    = step_t'(5);
    localparam step_t S_LD_ADT   = step_t'(6);
    localparam step_t S_LD_BDT   = step_t'(7);
    localparam step_t S_COEF_B   = step_t'(8);
    localparam step_t S_MUL_Y    = step_t'(9);
    localparam step_t S_MUL_X    = step_t'(10);
    localparam step_t S_MUL_XP   = step_t'(11);
    localparam step_t S_ACC_LAST = step_t'(12);
    localparam step_t S_PREP     = step_t'(13);
    localparam step_t S_DIV_INIT = step_t'(14);
    localparam step_t S_DIV      = step_t'(15);
    localparam step_t S_FIN      = step_t'(16);
    localparam step_t S_SAT_OVF  = step_t'(17);
    localparam step_t S_ZDIV     = step_t'(18);
    localparam step_t S_OUT      = step_t'(19);

    // Product shifted right by FRAC_BITS (toward minus infinity), then saturated.
    function automatic sat_res_t sat_prod(prod_t p);
        sat_res_t r;
        logic [PROD_W-FRAC_BITS-DATA_W:0] upper;
        upper = p[PROD_W-1:FRAC_BITS+DATA_W-1];
        r.val = p[FRAC_BITS+DATA_W-1:FRAC_BITS];
        r.ovf = 1'b0;
        if (!((&upper) || (~|upper)))
        begin
            r.ovf = 1'b1;
            r.val = p[PROD_W-1] ? DATA_MIN : DATA_MAX;
        end
        return r;
    endfunction

    function automatic uword_t ucode(step_t pc);
        uword_t w;
        w.mula    = MA_SAMPLE;
        w.mulb    = MB_GAIN;
        w.mul_en  = 1'b0;
        w.coef_op = CO_HOLD;
        w.acc_op  = AO_HOLD;
        w.act     = ACT_NONE;
        w.jmp     = J_NEXT;
        w.target  = S_IDLE;
        case (pc)
            S_IDLE:
            begin
                w.act = ACT_LOAD;
                w.jmp = J_WAIT_IN;
            end
            S_MUL_SG:
            begin
                w.mula   = MA_SAMPLE;
                w.mulb   = MB_GAIN;
                w.mul_en = 1'b1;
            end
            S_SAT_T:   w.act = ACT_SAT_T;
            S_ADD_OFS: w.act = ACT_ADD_OFS;
            S_MUL_DC:
            begin
                w.mula   = MA_TEMP;
                w.mulb   = MB_DC;
                w.mul_en = 1'b1;
            end
            S_SAT_X:
            begin
                w.act    = ACT_SAT_X;
                w.mula   = MA_ZERO;
                w.mulb   = MB_DT;
                w.mul_en = 1'b1;
            end
            S_LD_ADT:
            begin
                w.act    = ACT_LD_ADT;
                w.mula   = MA_POLE;
                w.mulb   = MB_DT;
                w.mul_en = 1'b1;
            end
            S_LD_BDT:  w.act = ACT_LD_BDT;
            S_COEF_B:  w.coef_op = CO_TWO_MINUS_B;
            S_MUL_Y:
            begin
                w.mula    = MA_COEF;
                w.mulb    = MB_YPREV;
                w.mul_en  = 1'b1;
                w.coef_op = CO_A_PLUS_TWO;
            end
            S_MUL_X:
            begin
                w.mula    = MA_COEF;
                w.mulb    = MB_X;
                w.mul_en  = 1'b1;
                w.acc_op  = AO_SET;
                w.coef_op = CO_A_MINUS_TWO;
            end
            S_MUL_XP:
            begin
                w.mula    = MA_COEF;
                w.mulb    = MB_XPREV;
                w.mul_en  = 1'b1;
                w.acc_op  = AO_ADD;
                w.coef_op = CO_TWO_PLUS_B;
            end
            S_ACC_LAST: w.acc_op = AO_ADD;
            S_PREP:
            begin
                w.act    = ACT_PREP;
                w.jmp    = J_DEN_ZERO;
                w.target = S_ZDIV;
            end
            S_DIV_INIT:
            begin
                w.act    = ACT_DIV_INIT;
                w.jmp    = J_QUO_OVF;
                w.target = S_SAT_OVF;
            end
            S_DIV:
            begin
                w.act    = ACT_DIV;
                w.jmp    = J_LOOP;
                w.target = S_DIV;
            end
            S_FIN:
            begin
                w.act    = ACT_FIN;
                w.jmp    = J_ALWAYS;
                w.target = S_OUT;
            end
            S_SAT_OVF:
            begin
                w.act    = ACT_SAT_OVF;
                w.jmp    = J_ALWAYS;
                w.target = S_OUT;
            end
            S_ZDIV:    w.act = ACT_ZDIV;
            S_OUT:
            begin
                w.act    = ACT_OUT;
                w.jmp    = J_WAIT_OUT;
                w.target = S_IDLE;
            end
            default:
            begin
                w.jmp    = J_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* sv/llf_if.sv */
// Channel interfaces of the lead-lag filter: the sample channel and the
// result channel, each with valid, ready and its payload.
// Depends on llf_pkg for the field widths.
interface llf_sample_if;
    logic                              valid;
    logic                              ready;
    logic signed [llf_pkg::DATA_W-1:0] sample;
    logic [llf_pkg::DT_W-1:0]          time_step;

    modport source(output valid, output sample, output time_step, input ready);
    modport sink(input valid, input sample, input time_step, output ready);
endinterface

interface llf_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [llf_pkg::DATA_W-1:0] filtered;
    logic                              overflow;

    modport source(output valid, output filtered, output overflow, input ready);
    modport sink(input valid, input filtered, input overflow, output ready);
endinterface

/* sv/lead_lag_filter.sv */
// Top level of the first-order lead-lag filter: configuration registers,
// fixed-point datapath and output register. Depends on llf_pkg, llf_if and
// llf_sequencer.
//
// The filter takes one sample transaction at a time and returns one result
// transaction for it. A control program steps a single 33x33 multiplier, an
// accumulator and a restoring divider that yields one quotient bit per cycle.
// A transaction runs the division unless the quotient is known to saturate
// or the divisor is zero. The program returns to the idle step, where the
// next sample is accepted, in the cycle after the result is loaded, so a new
// transaction starts only once the previous one is through. The output
// register holds a finished result while the next sample is accepted; the
// program waits only if a second result is ready before the first has been
// taken.
module lead_lag_filter
(
    input  logic                                clk,
    input  logic                                rst_n,
    llf_sample_if.sink                          samples,
    llf_result_if.source                        results,
    input  logic                                cfg_we,
    input  logic [llf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [llf_pkg::DATA_W-1:0]          cfg_data
);

    localparam int DW  = llf_pkg::DATA_W;
    localparam int OW  = llf_pkg::OPND_W;
    localparam int PW  = llf_pkg::PROD_W;
    localparam int AW  = llf_pkg::ACC_W;
    localparam int MW  = llf_pkg::MAG_W;
    localparam int DTW = llf_pkg::DT_W;

    llf_pkg::cond_t cond;
    llf_pkg::ctrl_t ctrl;
    llf_pkg::uword_t uw;

    llf_pkg::data_t zero_coef_reg;
    llf_pkg::data_t pole_coef_reg;
    llf_pkg::data_t dc_gain_reg;
    llf_pkg::data_t input_gain_reg;
    llf_pkg::data_t input_offset_reg;
    llf_pkg::data_t y_prev_reg;
    llf_pkg::data_t x_prev_reg;
    logic           out_valid_reg;

    llf_pkg::data_t  s_reg;
    llf_pkg::dt_t    dt_reg;
    llf_pkg::prod_t  prod_reg;
    llf_pkg::data_t  t_reg;
    llf_pkg::data_t  x_reg;
    llf_pkg::opnd_t  adt_reg;
    llf_pkg::opnd_t  bdt_reg;
    llf_pkg::opnd_t  coef_reg;
    llf_pkg::acc_t   acc_reg;
    logic [MW-1:0]   mag_reg;
    logic [OW-1:0]   dmag_reg;
    logic            neg_reg;
    logic [OW-1:0]   rem_reg;
    logic [DW-1:0]   quo_reg;
    llf_pkg::cnt_t   cnt_reg;
    llf_pkg::data_t  y_reg;
    logic            ovf_reg;
    llf_pkg::data_t  filtered_reg;
    logic            overflow_reg;

    llf_pkg::opnd_t   mul_a;
    llf_pkg::opnd_t   mul_b;
    llf_pkg::prod_t   prod_next;
    llf_pkg::sat_res_t sat_p;
    logic [OW-1:0]    ofs_sum;
    llf_pkg::opnd_t   coef_next;
    llf_pkg::acc_t    acc_neg;
    logic [OW-1:0]    coef_neg;
    logic [OW+1:0]    div_diff;
    logic             div_ge;
    logic             fire;

    assign uw   = ctrl.uw;
    assign fire = ctrl.go;

    assign cond.in_valid = samples.valid;
    assign cond.out_busy = out_valid_reg && !results.ready;
    assign cond.den_zero = (coef_reg == '0);
    assign cond.quo_ovf  = (mag_reg[MW-1:DW] >= {{(MW-DW-OW){1'b0}}, dmag_reg});
    assign cond.cnt_zero = (cnt_reg == '0);

    llf_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    assign samples.ready    = (uw.jmp == llf_pkg::J_WAIT_IN);
    assign results.valid    = out_valid_reg;
    assign results.filtered = filtered_reg;
    assign results.overflow = overflow_reg;

    always_comb
    begin
        case (uw.mula)
            llf_pkg::MA_SAMPLE: mul_a = {s_reg[DW-1], s_reg};
            llf_pkg::MA_TEMP:   mul_a = {t_reg[DW-1], t_reg};
            llf_pkg::MA_ZERO:   mul_a = {zero_coef_reg[DW-1], zero_coef_reg};
            llf_pkg::MA_POLE:   mul_a = {pole_coef_reg[DW-1], pole_coef_reg};
            llf_pkg::MA_COEF:   mul_a = coef_reg;
            default:            mul_a = coef_reg;
        endcase
        case (uw.mulb)
            llf_pkg::MB_GAIN:  mul_b = {input_gain_reg[DW-1], input_gain_reg};
            llf_pkg::MB_DC:    mul_b = {dc_gain_reg[DW-1], dc_gain_reg};
            llf_pkg::MB_DT:    mul_b = {{(OW-DTW){1'b0}}, dt_reg};
            llf_pkg::MB_YPREV: mul_b = {y_prev_reg[DW-1], y_prev_reg};
            llf_pkg::MB_X:     mul_b = {x_reg[DW-1], x_reg};
            llf_pkg::MB_XPREV: mul_b = {x_prev_reg[DW-1], x_prev_reg};
            default:           mul_b = {x_reg[DW-1], x_reg};
        endcase
        prod_next = mul_a * mul_b;
        case (uw.coef_op)
            llf_pkg::CO_TWO_MINUS_B: coef_next = llf_pkg::FIX_TWO - bdt_reg;
            llf_pkg::CO_A_PLUS_TWO:  coef_next = adt_reg + llf_pkg::FIX_TWO;
            llf_pkg::CO_A_MINUS_TWO: coef_next = adt_reg - llf_pkg::FIX_TWO;
            llf_pkg::CO_TWO_PLUS_B:  coef_next = llf_pkg::FIX_TWO + bdt_reg;
            default:                 coef_next = coef_reg;
        endcase
    end

    assign sat_p    = llf_pkg::sat_prod(prod_reg);
    assign ofs_sum  = {t_reg[DW-1], t_reg} + {input_offset_reg[DW-1], input_offset_reg};
    assign acc_neg  = -acc_reg;
    assign coef_neg = -coef_reg;
    assign div_diff = {1'b0, rem_reg, quo_reg[DW-1]} - {2'b00, dmag_reg};
    assign div_ge   = !div_diff[OW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_coef_reg    <= '0;
            pole_coef_reg    <= '0;
            dc_gain_reg      <= '0;
            input_gain_reg   <= llf_pkg::GAIN_ONE;
            input_offset_reg <= '0;
            y_prev_reg       <= '0;
            x_prev_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    llf_pkg::REG_ZERO_COEF:    zero_coef_reg    <= cfg_data;
                    llf_pkg::REG_POLE_COEF:    pole_coef_reg    <= cfg_data;
                    llf_pkg::REG_DC_GAIN:      dc_gain_reg      <= cfg_data;
                    llf_pkg::REG_INPUT_GAIN:   input_gain_reg   <= cfg_data;
                    llf_pkg::REG_INPUT_OFFSET: input_offset_reg <= cfg_data;
                    default:                   ;
                endcase
            end
            if (fire && uw.act == llf_pkg::ACT_OUT)
            begin
                out_valid_reg <= 1'b1;
                y_prev_reg    <= y_reg;
                x_prev_reg    <= x_reg;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (uw.mul_en)
            begin
                prod_reg <= prod_next;
            end
            coef_reg <= coef_next;
            case (uw.acc_op)
                llf_pkg::AO_SET: acc_reg <= {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
                llf_pkg::AO_ADD: acc_reg <= acc_reg + {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
                default:         acc_reg <= acc_reg;
            endcase
            case (uw.act)
                llf_pkg::ACT_LOAD:
                begin
                    s_reg   <= samples.sample;
                    dt_reg  <= samples.time_step;
                    ovf_reg <= 1'b0;
                end
                llf_pkg::ACT_SAT_T:
                begin
                    t_reg <= sat_p.val;
                    if (sat_p.ovf)
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                llf_pkg::ACT_ADD_OFS:
                begin
                    if (ofs_sum[OW-1] != ofs_sum[DW-1])
                    begin
                        ovf_reg <= 1'b1;
                        t_reg   <= ofs_sum[OW-1] ? llf_pkg::DATA_MIN : llf_pkg::DATA_MAX;
                    end
                    else
                    begin
                        t_reg <= ofs_sum[DW-1:0];
                    end
                end
                llf_pkg::ACT_SAT_X:
                begin
                    x_reg <= sat_p.val;
                    if (sat_p.ovf)
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                llf_pkg::ACT_LD_ADT:
                begin
                    adt_reg <= prod_reg[llf_pkg::DT_FRAC+OW-1:llf_pkg::DT_FRAC];
                end
                llf_pkg::ACT_LD_BDT:
                begin
                    bdt_reg <= prod_reg[llf_pkg::DT_FRAC+OW-1:llf_pkg::DT_FRAC];
                end
                llf_pkg::ACT_PREP:
                begin
                    mag_reg  <= acc_reg[AW-1] ? acc_neg[MW-1:0] : acc_reg[MW-1:0];
                    dmag_reg <= coef_reg[OW-1] ? coef_neg : coef_reg;
                    neg_reg  <= acc_reg[AW-1] ^ coef_reg[OW-1];
                end
                llf_pkg::ACT_DIV_INIT:
                begin
                    rem_reg <= mag_reg[DW+OW-1:DW];
                    quo_reg <= mag_reg[DW-1:0];
                    cnt_reg <= llf_pkg::DIV_LAST;
                end
                llf_pkg::ACT_DIV:
                begin
                    rem_reg <= div_ge ? div_diff[OW-1:0] : {rem_reg[OW-2:0], quo_reg[DW-1]};
                    quo_reg <= {quo_reg[DW-2:0], div_ge};
                    cnt_reg <= cnt_reg - llf_pkg::cnt_t'(1);
                end
                llf_pkg::ACT_FIN:
                begin
                    if (neg_reg)
                    begin
                        if (quo_reg[DW-1] && (|quo_reg[DW-2:0]))
                        begin
                            y_reg   <= llf_pkg::DATA_MIN;
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            y_reg <= -quo_reg;
                        end
                    end
                    else if (quo_reg[DW-1])
                    begin
                        y_reg   <= llf_pkg::DATA_MAX;
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        y_reg <= quo_reg;
                    end
                end
                llf_pkg::ACT_SAT_OVF:
                begin
                    y_reg   <= neg_reg ? llf_pkg::DATA_MIN : llf_pkg::DATA_MAX;
                    ovf_reg <= 1'b1;
                end
                llf_pkg::ACT_ZDIV:
                begin
                    ovf_reg <= 1'b1;
                    if (acc_reg[AW-1])
                    begin
                        y_reg <= llf_pkg::DATA_MIN;
                    end
                    else if (acc_reg != '0)
                    begin
                        y_reg <= llf_pkg::DATA_MAX;
                    end
                    else
                    begin
                        y_reg <= '0;
                    end
                end
                llf_pkg::ACT_OUT:
                begin
                    filtered_reg <= y_reg;
                    overflow_reg <= ovf_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* sv/llf_sequencer.sv */
// Microcode sequencer of the lead-lag filter: step counter, control table
// lookup and conditional jumps. Depends on llf_pkg for the program and types.
module llf_sequencer
(
    input  logic            clk,
    input  logic            rst_n,
    input  llf_pkg::cond_t  cond,
    output llf_pkg::ctrl_t  ctrl
);

    llf_pkg::step_t pc_reg;
    llf_pkg::step_t pc_next;
    llf_pkg::uword_t uw;
    logic go;
    logic taken;

    always_comb
    begin
        uw    = llf_pkg::ucode(pc_reg);
        go    = 1'b1;
        taken = 1'b0;
        unique case (uw.jmp)
            llf_pkg::J_NEXT:     taken = 1'b0;
            llf_pkg::J_ALWAYS:   taken = 1'b1;
            llf_pkg::J_WAIT_IN:  go = cond.in_valid;
            llf_pkg::J_WAIT_OUT:
            begin
                go    = !cond.out_busy;
                taken = 1'b1;
            end
            llf_pkg::J_DEN_ZERO: taken = cond.den_zero;
            llf_pkg::J_QUO_OVF:  taken = cond.quo_ovf;
            llf_pkg::J_LOOP:     taken = !cond.cnt_zero;
            default:             taken = 1'b1;
        endcase
        if (!go)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + llf_pkg::step_t'(1);
        end
        ctrl.uw = uw;
        ctrl.go = go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= llf_pkg::S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
